FILE: sv/stereo_interpolating_sample_player_top_defines.svh
// assertion macros shared by the sample player rtl
`ifndef STEREO_INTERPOLATING_SAMPLE_PLAYER_TOP_DEFINES_SVH
`define STEREO_INTERPOLATING_SAMPLE_PLAYER_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define SISP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define SISP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/sisp_pkg.sv
`default_nettype none
package sisp_pkg;

	// fixed point geometry
	localparam int MAX_SAMPLES = 65536;
	localparam int SAMPLE_W    = 24;
	localparam int FRAC_W      = 16;
	localparam int RATE_W      = 24;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int PH_W        = 34;
	localparam int PAIR_W      = 2 * SAMPLE_W;
	localparam int PROD_W      = (SAMPLE_W + 1) + (FRAC_W + 1);

	// request operation codes
	typedef enum logic [1:0] {
		OP_PLAY   = 2'd0,
		OP_LOAD   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_REWIND = 2'd3
	} op_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_WAIT
	} state_t;

endpackage
`default_nettype wire

FILE: sv/sisp_in_if.sv
`default_nettype none
interface sisp_in_if import sisp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	op_t                        op;
	logic                       load_first;
	logic signed [SAMPLE_W-1:0] sample_left;
	logic signed [SAMPLE_W-1:0] sample_right;
	logic        [RATE_W-1:0]   rate;

	modport source (output valid, op, load_first, sample_left, sample_right, rate,
		input ready);
	modport sink (input valid, op, load_first, sample_left, sample_right, rate,
		output ready);
endinterface
`default_nettype wire

FILE: sv/sisp_out_if.sv
`default_nettype none
interface sisp_out_if import sisp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_left;
	logic signed [SAMPLE_W-1:0] out_right;
	logic                       finished;
	logic                       dropped;

	modport source (output valid, out_left, out_right, finished, dropped, input ready);
	modport sink (input valid, out_left, out_right, finished, dropped, output ready);
endinterface
`default_nettype wire

FILE: sv/sisp_ram.sv
`default_nettype none
module sisp_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
`default_nettype wire

FILE: sv/stereo_interpolating_sample_player_top.sv
// channel  dir  payload                                          request taken when
// cmd      in   op, load_first, sample_left, sample_right, rate  valid && ready
// rsp      out  out_left, out_right, finished, dropped           valid && ready
//
// load, clear, rewind and a finished play step hold the block through the hand-over state; the result
// passes from the pending result register into the output register.
// a live play step holds it through store read at acceptance, interpolation
// multiply, add, then hand-over to the output register.
// one request is in work at a time; cmd.ready is high again once its result sits
// in the output register, so the next request is taken while that result waits.
// a stalled rsp holds the sequencer in its hand-over cycle with cmd.ready low.
// arst_n clears length, playhead and control; store contents stay undefined.
`default_nettype none
`include "stereo_interpolating_sample_player_top_defines.svh"
module stereo_interpolating_sample_player_top import sisp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	sisp_in_if.sink  cmd,
	sisp_out_if.source rsp
);

	state_t state_q, state_d;

	logic [LEN_W-1:0] len_q;
	logic [PH_W-1:0]  playhead_q;

	logic accept;
	logic out_free;
	logic load_out;

	// play step decode from current state
	logic [LEN_W-1:0] len_m1;
	logic [PH_W-1:0]  end_pos;
	logic             play_fin;
	logic [ADDR_W-1:0] idx0, idx1;

	// load decode
	logic [LEN_W-1:0] len_eff;
	logic             load_full;

	// store ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [PAIR_W-1:0] ram_wdata;
	logic              ram_re;
	logic [PAIR_W-1:0] ram_rdata_a, ram_rdata_b;

	// pipeline registers
	logic [FRAC_W-1:0]          frac_s1;
	logic signed [PROD_W-1:0]   prod_l_s2, prod_r_s2;
	logic signed [SAMPLE_W-1:0] base_l_s2, base_r_s2;

	// pending result
	logic signed [SAMPLE_W-1:0] res_l_q, res_r_q;
	logic                       res_fin_q, res_drop_q;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_l_q, out_r_q;
	logic                       out_fin_q, out_drop_q;

	assign accept   = cmd.valid && cmd.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign load_out = (state_q == ST_WAIT) && out_free;

	// end of playback test
	assign len_m1   = len_q - LEN_W'(1);
	assign end_pos  = (len_q == '0) ? '0 : (PH_W'(len_m1) << FRAC_W);
	assign play_fin = (len_q < LEN_W'(2)) || (playhead_q >= end_pos);
	assign idx0     = playhead_q[FRAC_W +: ADDR_W];
	assign idx1     = idx0 + ADDR_W'(1);

	// load position and full test
	assign len_eff   = cmd.load_first ? '0 : len_q;
	assign load_full = len_eff[LEN_W-1];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (cmd.op == OP_PLAY && !play_fin) ? ST_READ : ST_WAIT;
				end
			end
			ST_READ: state_d = ST_SUM;
			ST_SUM:  state_d = ST_WAIT;
			ST_WAIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and store control
	always_comb begin
		cmd.ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				ram_we    = cmd.valid && cmd.op == OP_LOAD && !load_full;
				ram_re    = cmd.valid && cmd.op == OP_PLAY && !play_fin;
			end
			default: begin
				cmd.ready = 1'b0;
			end
		endcase
	end

	assign ram_waddr = len_eff[ADDR_W-1:0];
	assign ram_wdata = {cmd.sample_left, cmd.sample_right};

	sisp_ram #(
		.WIDTH(PAIR_W),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr_a(idx0),
		.raddr_b(idx1),
		.rdata_a(ram_rdata_a),
		.rdata_b(ram_rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// length and playhead update at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			playhead_q <= '0;
		end else if (accept) begin
			case (cmd.op)
				OP_PLAY: begin
					if (!play_fin) begin
						playhead_q <= playhead_q + PH_W'(cmd.rate);
					end
				end
				OP_LOAD: begin
					if (!load_full) begin
						len_q <= len_eff + LEN_W'(1);
					end else begin
						len_q <= len_eff;
					end
				end
				OP_CLEAR: begin
					len_q      <= '0;
					playhead_q <= '0;
				end
				OP_REWIND: playhead_q <= '0;
				default: playhead_q <= playhead_q;
			endcase
		end
	end

	// interpolation multiply: base + (next - base) * frac
	logic signed [SAMPLE_W:0]   diff_l, diff_r;
	logic signed [FRAC_W:0]     frac_sg;
	logic signed [SAMPLE_W-1:0] a_l, a_r, b_l, b_r;

	assign a_l     = ram_rdata_a[PAIR_W-1 -: SAMPLE_W];
	assign a_r     = ram_rdata_a[SAMPLE_W-1:0];
	assign b_l     = ram_rdata_b[PAIR_W-1 -: SAMPLE_W];
	assign b_r     = ram_rdata_b[SAMPLE_W-1:0];
	assign diff_l  = (SAMPLE_W+1)'(b_l) - (SAMPLE_W+1)'(a_l);
	assign diff_r  = (SAMPLE_W+1)'(b_r) - (SAMPLE_W+1)'(a_r);
	assign frac_sg = $signed({1'b0, frac_s1});

	always_ff @(posedge clk) begin
		if (accept) begin
			frac_s1 <= playhead_q[FRAC_W-1:0];
		end
		if (state_q == ST_READ) begin
			prod_l_s2 <= PROD_W'(diff_l * frac_sg);
			prod_r_s2 <= PROD_W'(diff_r * frac_sg);
			base_l_s2 <= a_l;
			base_r_s2 <= a_r;
		end
	end

	// floor of the scaled product plus base
	logic signed [PROD_W-1:0] sum_l, sum_r;

	assign sum_l = PROD_W'(base_l_s2) + (prod_l_s2 >>> FRAC_W);
	assign sum_r = PROD_W'(base_r_s2) + (prod_r_s2 >>> FRAC_W);

	// pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			res_l_q    <= '0;
			res_r_q    <= '0;
			res_fin_q  <= cmd.op == OP_PLAY && play_fin;
			res_drop_q <= cmd.op == OP_LOAD && load_full;
		end else if (state_q == ST_SUM) begin
			res_l_q <= sum_l[SAMPLE_W-1:0];
			res_r_q <= sum_r[SAMPLE_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_l_q    <= res_l_q;
			out_r_q    <= res_r_q;
			out_fin_q  <= res_fin_q;
			out_drop_q <= res_drop_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_left  = out_l_q;
	assign rsp.out_right = out_r_q;
	assign rsp.finished  = out_fin_q;
	assign rsp.dropped   = out_drop_q;

	// checks
	`SISP_ASSERT_NOW(a_len_bound, 1'b1, len_q <= LEN_W'(MAX_SAMPLES),
		"sample length beyond store capacity")
	`SISP_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE,
		"sequencer idle after accepting a request")
	`SISP_ASSERT_NOW(a_sum_order, state_q == ST_SUM, $past(state_q) == ST_READ,
		"add stage entered without a store read")
	`SISP_ASSERT_NOW(a_flags_excl, rsp.valid, !(rsp.finished && rsp.dropped),
		"finished and dropped raised together")
	`SISP_ASSERT_NOW(a_we_idle, ram_we, state_q == ST_IDLE && !ram_re,
		"store written outside acceptance")

endmodule
`default_nettype wire

FILE: sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sisp_pkg::*;

	// one request as driven on cmd
	typedef struct packed {
		op_t                        op;
		logic                       load_first;
		logic signed [SAMPLE_W-1:0] sample_left;
		logic signed [SAMPLE_W-1:0] sample_right;
		logic        [RATE_W-1:0]   rate;
	} req_t;

	// one result as seen on rsp
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_left;
		logic signed [SAMPLE_W-1:0] out_right;
		logic                       finished;
		logic                       dropped;
	} result_t;

	// directed row: request plus an optional hand-written result
	typedef struct packed {
		req_t    req;
		logic    has_want;
		result_t want;
	} vector_t;

	localparam logic signed [SAMPLE_W-1:0] S_MAX  = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN  = 24'sh800000;
	localparam logic signed [SAMPLE_W-1:0] S_ZERO = 24'sh000000;
	localparam logic [RATE_W-1:0]          R_MAX  = 24'hFFFFFF;
	localparam logic [RATE_W-1:0]          R_ONE  = 24'h010000;

	localparam result_t NO_OUTPUT   = '{S_ZERO, S_ZERO, 1'b0, 1'b0};
	localparam result_t END_OF_DATA = '{S_ZERO, S_ZERO, 1'b1, 1'b0};

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 20;
	localparam int PHASE_ITEMS    = 312;
	localparam int DIRECTED_ROWS  = 26;

	logic clk;
	logic arst_n;

	sisp_in_if  cmd ();
	sisp_out_if rsp ();

	stereo_interpolating_sample_player_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	// player state mirror
	logic signed [SAMPLE_W-1:0] left_store  [MAX_SAMPLES];
	logic signed [SAMPLE_W-1:0] right_store [MAX_SAMPLES];
	logic        [LEN_W-1:0]    fill_count;
	logic        [PH_W-1:0]     play_pos;

	result_t expected_results [$];
	int      error_count;
	int      sent_count;
	int      idle_pct;
	int      stall_pct;

	// walk of the basic cases from reset
	vector_t directed [DIRECTED_ROWS] = '{
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, R_ONE},      1'b1, END_OF_DATA},
		'{'{OP_REWIND, 1'b0, S_ZERO, S_ZERO, 24'h0},      1'b1, NO_OUTPUT},
		'{'{OP_CLEAR,  1'b0, S_ZERO, S_ZERO, 24'h0},      1'b1, NO_OUTPUT},
		'{'{OP_LOAD,   1'b1, S_MAX,  S_MIN,  24'h0},      1'b1, NO_OUTPUT},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, R_ONE},      1'b1, END_OF_DATA},
		'{'{OP_LOAD,   1'b0, S_MIN,  S_MAX,  24'h0},      1'b1, NO_OUTPUT},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, 24'h008000}, 1'b1, '{S_MAX, S_MIN, 1'b0, 1'b0}},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, R_MAX},      1'b0, NO_OUTPUT},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, 24'h0},      1'b1, END_OF_DATA},
		'{'{OP_LOAD,   1'b0, S_ZERO, S_ZERO, R_MAX},      1'b1, NO_OUTPUT},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, 24'h0},      1'b1, END_OF_DATA},
		'{'{OP_REWIND, 1'b1, S_MAX,  S_MIN,  R_MAX},      1'b1, NO_OUTPUT},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, 24'h00C000}, 1'b1, '{S_MAX, S_MIN, 1'b0, 1'b0}},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, 24'h004000}, 1'b0, NO_OUTPUT},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, 24'h0},      1'b1, '{S_MIN, S_MAX, 1'b0, 1'b0}},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, 24'h00FFFF}, 1'b1, '{S_MIN, S_MAX, 1'b0, 1'b0}},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, 24'h000001}, 1'b0, NO_OUTPUT},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, R_ONE},      1'b1, END_OF_DATA},
		'{'{OP_LOAD,   1'b1, 24'sh000001, 24'shFFFFFF, 24'h0}, 1'b1, NO_OUTPUT},
		'{'{OP_LOAD,   1'b0, 24'shAAAAAA, 24'sh555555, 24'h0}, 1'b1, NO_OUTPUT},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, R_ONE},      1'b1, END_OF_DATA},
		'{'{OP_REWIND, 1'b0, S_ZERO, S_ZERO, 24'h0},      1'b1, NO_OUTPUT},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, 24'h018000},
			1'b1, '{24'sh000001, 24'shFFFFFF, 1'b0, 1'b0}},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, R_ONE},      1'b1, END_OF_DATA},
		'{'{OP_CLEAR,  1'b1, S_MIN,  S_MAX,  R_MAX},      1'b1, NO_OUTPUT},
		'{'{OP_PLAY,   1'b0, S_ZERO, S_ZERO, R_ONE},      1'b1, END_OF_DATA}
	};

	// floor of the weighted sum of two neighbours
	function automatic logic signed [SAMPLE_W-1:0] blend(
		input logic signed [SAMPLE_W-1:0] a,
		input logic signed [SAMPLE_W-1:0] b,
		input logic        [FRAC_W-1:0]   frac
	);
		longint acc;
		acc = longint'(a) * ((longint'(1) <<< FRAC_W) - longint'(frac))
			+ longint'(b) * longint'(frac);
		acc = acc >>> FRAC_W;
		return acc[SAMPLE_W-1:0];
	endfunction

	// advance the player mirror by one request and give its result
	task automatic step_player(input req_t r, output result_t res);
		logic [PH_W-1:0]   end_pos;
		logic [ADDR_W-1:0] lo_idx;
		logic [FRAC_W-1:0] frac;
		res = NO_OUTPUT;
		case (r.op)
			OP_PLAY: begin
				end_pos = {{(PH_W-LEN_W){1'b0}}, fill_count} - 1'b1;
				end_pos = end_pos << FRAC_W;
				if (fill_count < 2 || play_pos >= end_pos) begin
					res.finished = 1'b1;
				end else begin
					lo_idx = play_pos[FRAC_W +: ADDR_W];
					frac   = play_pos[FRAC_W-1:0];
					res.out_left  = blend(left_store[lo_idx], left_store[lo_idx + 1'b1], frac);
					res.out_right = blend(right_store[lo_idx], right_store[lo_idx + 1'b1], frac);
					play_pos = play_pos + {{(PH_W-RATE_W){1'b0}}, r.rate};
				end
			end
			OP_LOAD: begin
				if (r.load_first)
					fill_count = '0;
				if (fill_count >= MAX_SAMPLES) begin
					res.dropped = 1'b1;
				end else begin
					left_store[fill_count[ADDR_W-1:0]]  = r.sample_left;
					right_store[fill_count[ADDR_W-1:0]] = r.sample_right;
					fill_count = fill_count + 1'b1;
				end
			end
			OP_CLEAR: begin
				fill_count = '0;
				play_pos   = '0;
			end
			OP_REWIND: begin
				play_pos = '0;
			end
			default: begin
			end
		endcase
	endtask

	// sample values leaning on the extremes
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2: return S_ZERO;
			default: return w[SAMPLE_W-1:0];
		endcase
	endfunction

	// step rates: mostly slow enough to walk through short stores
	function automatic logic [RATE_W-1:0] pick_rate();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(9))
			0: return '0;
			1, 2, 3: return RATE_W'($urandom_range(1, 'h2FFFF));
			4, 5: return RATE_W'($urandom_range(1, 'hFFFF));
			6: return RATE_W'($urandom_range(1, 3)) << FRAC_W;
			7: return RATE_W'($urandom_range('h10000, 'h7FFFF));
			default: return w[RATE_W-1:0];
		endcase
	endfunction

	function automatic req_t make_req(input op_t op, input logic first);
		req_t r;
		r.op           = op;
		r.load_first   = first;
		r.sample_left  = pick_sample();
		r.sample_right = pick_sample();
		r.rate         = pick_rate();
		return r;
	endfunction

	// any op, every field uniformly random
	function automatic req_t noise_req();
		req_t        r;
		logic [31:0] wl;
		logic [31:0] wr;
		logic [31:0] wt;
		wl = $urandom;
		wr = $urandom;
		wt = $urandom;
		r.op           = op_t'($urandom_range(3));
		r.load_first   = wt[31];
		r.sample_left  = wl[SAMPLE_W-1:0];
		r.sample_right = wr[SAMPLE_W-1:0];
		r.rate         = wt[RATE_W-1:0];
		return r;
	endfunction

	// drive one request, wait for acceptance, then log its result
	task automatic send_request(input req_t r, input logic has_want, input result_t want);
		result_t model_out;
		while ($urandom_range(99) < idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid        <= 1'b1;
		cmd.op           <= r.op;
		cmd.load_first   <= r.load_first;
		cmd.sample_left  <= r.sample_left;
		cmd.sample_right <= r.sample_right;
		cmd.rate         <= r.rate;
		do @(posedge clk); while (!cmd.ready);
		step_player(r, model_out);
		expected_results.push_back(has_want ? want : model_out);
		sent_count++;
	endtask

	// hold off requests until every result is back
	task automatic drain();
		cmd.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// optionally clear, load a short store, optionally rewind, then play through it
	task automatic run_phrase();
		int                pairs;
		int                steps;
		logic [RATE_W-1:0] step_rate;
		req_t              r;
		if ($urandom_range(3) == 0)
			send_request(make_req(OP_CLEAR, 1'b0), 1'b0, NO_OUTPUT);
		pairs = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
		for (int k = 0; k < pairs; k++)
			send_request(make_req(OP_LOAD, k == 0 && $urandom_range(4) != 0), 1'b0, NO_OUTPUT);
		if ($urandom_range(9) < 7)
			send_request(make_req(OP_REWIND, 1'b0), 1'b0, NO_OUTPUT);
		step_rate = pick_rate();
		steps = $urandom_range(2, 30);
		for (int k = 0; k < steps; k++) begin
			// occasional append or rewind in the middle of playback
			if ($urandom_range(11) == 0)
				send_request(make_req(op_t'($urandom_range(1) ? OP_LOAD : OP_REWIND), 1'b0),
					1'b0, NO_OUTPUT);
			if ($urandom_range(3) == 0)
				step_rate = pick_rate();
			r = make_req(OP_PLAY, 1'b0);
			r.rate = step_rate;
			send_request(r, 1'b0, NO_OUTPUT);
		end
	endtask

	task automatic check_field(input string field, input logic [SAMPLE_W-1:0] want,
		input logic [SAMPLE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", field, want, got);
			error_count++;
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver back-pressure
	initial rsp.ready = 1'b0;
	always @(posedge clk) begin
		rsp.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: left %h right %h finished %b dropped %b",
					rsp.out_left, rsp.out_right, rsp.finished, rsp.dropped);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("out_left", want.out_left, rsp.out_left);
				check_field("out_right", want.out_right, rsp.out_right);
				check_field("finished", SAMPLE_W'(want.finished), SAMPLE_W'(rsp.finished));
				check_field("dropped", SAMPLE_W'(want.dropped), SAMPLE_W'(rsp.dropped));
			end
		end
	end

	// watchdog on cycles with no request or result moving
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// stimulus
	initial begin
		int   idle_mix  [4];
		int   stall_mix [4];
		int   target;
		idle_mix  = '{0, 47, 0, 8};
		stall_mix = '{0, 0, 47, 8};
		error_count = 0;
		sent_count  = 0;
		idle_pct    = 0;
		stall_pct   = 0;
		fill_count  = '0;
		play_pos    = '0;
		cmd.valid        = 1'b0;
		cmd.op           = OP_PLAY;
		cmd.load_first   = 1'b0;
		cmd.sample_left  = '0;
		cmd.sample_right = '0;
		cmd.rate         = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed[i])
			send_request(directed[i].req, directed[i].has_want, directed[i].want);
		drain();

		// random phrases and noise under each idle and stall mix
		for (int p = 0; p < 4; p++) begin
			idle_pct  = idle_mix[p];
			stall_pct = stall_mix[p];
			target = sent_count + PHASE_ITEMS;
			while (sent_count < target) begin
				if ($urandom_range(9) < 8)
					run_phrase();
				else
					repeat ($urandom_range(1, 3))
						send_request(noise_req(), 1'b0, NO_OUTPUT);
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
